// ===== rtl/core/kpc_pkg.sv =====
// shared types and constants for the key press classifier
`default_nettype none
package kpc_pkg;

  localparam int unsigned TIMER_W         = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned KEY_W           = 1;
  localparam int unsigned IN_TDATA_W      = 8;
  localparam int unsigned OUT_TDATA_W     = 8;
  localparam int unsigned NUM_KEYS_DEF    = 2;
  localparam int unsigned REPEAT_DEF      = 5;
  localparam logic [TIMER_W-1:0] TIMER_MAX       = '1;
  localparam logic [CFG_W-1:0]   LONG_RESET_VAL  = 16'd100;
  localparam logic [CFG_W-1:0]   WINDOW_RESET_VAL = 16'd12;

  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_LONG   = 2'd1,
    EV_DOUBLE = 2'd2
  } event_code_t;

  typedef enum logic [0:0] {
    REG_LONG_PRESS    = 1'b0,
    REG_DOUBLE_WINDOW = 1'b1
  } cfg_reg_t;

  // per-key timers and flags
  typedef struct packed {
    logic [TIMER_W-1:0] hold_timer;
    logic [TIMER_W-1:0] gap_timer;
    logic               press_active;
    logic               double_pending;
    logic               long_held;
  } key_state_t;

  // classifier verdict for one scan
  typedef struct packed {
    logic        valid;
    event_code_t code;
  } key_event_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == TIMER_MAX) ? v : v + TIMER_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kpc_classify.sv =====
// next-state and event logic for one key scan
`default_nettype none
module kpc_classify import kpc_pkg::*; #(
  parameter int unsigned REPEAT_PERIOD = REPEAT_DEF,
  localparam int unsigned PH_W = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1
) (
  input  key_state_t        cur,
  input  logic [PH_W-1:0]   phase,
  input  logic              released,
  input  logic              tick,
  input  logic [CFG_W-1:0]  long_press_ticks,
  input  logic [CFG_W-1:0]  double_window_ticks,
  output key_state_t        nxt,
  output logic [PH_W-1:0]   phase_next,
  output key_event_t        ev
);

  localparam logic [PH_W-1:0] PhLast = PH_W'(REPEAT_PERIOD - 1);

  logic ev_short;
  logic ev_double;

  always_comb begin
    nxt        = cur;
    phase_next = phase;
    ev_short   = 1'b0;
    ev_double  = 1'b0;
    ev         = '{valid: 1'b0, code: EV_SHORT};

    if (tick) begin
      // phase tracks hold_timer modulo the repeat period
      if (cur.hold_timer != TIMER_MAX) begin
        phase_next = (phase == PhLast) ? '0 : phase + PH_W'(1);
      end
      nxt.hold_timer = sat_inc(cur.hold_timer);
      nxt.gap_timer  = sat_inc(cur.gap_timer);
    end

    if (!released) begin
      if (!cur.press_active) begin
        nxt.press_active = 1'b1;
        nxt.hold_timer   = '0;
        phase_next       = '0;
      end else if (nxt.hold_timer > long_press_ticks) begin
        nxt.long_held    = 1'b1;
        nxt.press_active = 1'b0;
      end
    end else begin
      if (cur.press_active) begin
        nxt.press_active = 1'b0;
        if (!cur.double_pending) begin
          nxt.double_pending = 1'b1;
          nxt.gap_timer      = '0;
        end else if (nxt.gap_timer < double_window_ticks) begin
          nxt.double_pending = 1'b0;
          ev_double          = 1'b1;
        end
      end else if (cur.double_pending) begin
        if (nxt.gap_timer > double_window_ticks) begin
          nxt.double_pending = 1'b0;
          ev_short           = 1'b1;
        end
      end
      if (cur.long_held) begin
        nxt.long_held  = 1'b0;
        nxt.hold_timer = '0;
        nxt.gap_timer  = '0;
        phase_next     = '0;
      end
    end

    priority if (ev_short) begin
      nxt.hold_timer   = '0;
      nxt.press_active = 1'b0;
      phase_next       = '0;
      ev               = '{valid: 1'b1, code: EV_SHORT};
    end else if (ev_double) begin
      nxt.hold_timer     = '0;
      nxt.gap_timer      = '0;
      nxt.double_pending = 1'b0;
      phase_next         = '0;
      ev                 = '{valid: 1'b1, code: EV_DOUBLE};
    end else if (nxt.long_held && phase_next == '0) begin
      ev = '{valid: 1'b1, code: EV_LONG};
    end else begin
      ev = '{valid: 1'b0, code: EV_SHORT};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/key_press_classifier.sv =====
// key press classifier top level: scan register, per-key state, event register
//
//   channel | dir | handshake               | payload
//   s_*     | in  | s_tvalid / s_tready     | s_tdata: key_index, key_level, tick
//   m_*     | out | m_tvalid / m_tready     | m_tdata: event_key, event_code
//   cfg_*   | in  | cfg_wr_en               | cfg_addr, cfg_wr_data
//
// one scan per cycle unless the event register is held: a scan is captured in the
// input register, then the per-key state update and event decision happen in one pass
// into the event register; scans that give no event leave nothing.
// a held event register stalls the scan register, which then drops s_tready.
// rst clears all key state, the valid flags and restores the register defaults.
`default_nettype none
module key_press_classifier import kpc_pkg::*; #(
  parameter int unsigned NUM_KEYS      = NUM_KEYS_DEF,
  parameter int unsigned REPEAT_PERIOD = REPEAT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] key_index, [1] key_level, [2] tick
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] event_key, [2:1] event_code
  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  localparam int unsigned PH_W = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;

  logic [CFG_W-1:0] long_press_ticks;
  logic [CFG_W-1:0] double_window_ticks;

  // scan register
  logic             scan_valid;
  logic [KEY_W-1:0] scan_key;
  logic             scan_released;
  logic             scan_tick;

  // event register
  logic             ev_valid;
  logic [KEY_W-1:0] ev_key;
  event_code_t      ev_code;

  key_state_t       keys  [NUM_KEYS];
  logic [PH_W-1:0]  phases[NUM_KEYS];

  key_state_t       sel_state;
  logic [PH_W-1:0]  sel_phase;
  logic             key_ok;
  key_state_t       state_next;
  logic [PH_W-1:0]  phase_next;
  key_event_t       verdict;
  logic             advance;

  assign advance  = scan_valid && (!ev_valid || m_tready);
  assign s_tready = !scan_valid || advance;
  assign key_ok   = 32'(scan_key) < NUM_KEYS;

  always_comb begin
    sel_state = '0;
    sel_phase = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (32'(scan_key) == i) begin
        sel_state = keys[i];
        sel_phase = phases[i];
      end
    end
  end

  kpc_classify #(.REPEAT_PERIOD(REPEAT_PERIOD)) u_classify (
    .cur                 (sel_state),
    .phase               (sel_phase),
    .released            (scan_released),
    .tick                (scan_tick),
    .long_press_ticks    (long_press_ticks),
    .double_window_ticks (double_window_ticks),
    .nxt                 (state_next),
    .phase_next          (phase_next),
    .ev                  (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks    <= LONG_RESET_VAL;
      double_window_ticks <= WINDOW_RESET_VAL;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_LONG_PRESS:    long_press_ticks    <= cfg_wr_data;
        REG_DOUBLE_WINDOW: double_window_ticks <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (s_tready) begin
      scan_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      scan_key      <= s_tdata[0 +: KEY_W];
      scan_released <= s_tdata[1];
      scan_tick     <= s_tdata[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        keys[i]   <= '0;
        phases[i] <= '0;
      end
    end else if (advance && key_ok) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (32'(scan_key) == i) begin
          keys[i]   <= state_next;
          phases[i] <= phase_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (advance) begin
      ev_valid <= verdict.valid && key_ok;
    end else if (m_tready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_key  <= scan_key;
      ev_code <= verdict.code;
    end
  end

  assign m_tvalid = ev_valid;
  assign m_tdata  = {{(OUT_TDATA_W - KEY_W - 2){1'b0}}, ev_code, ev_key};

  // an empty event register never holds back a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("scan blocked with empty event register");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:1] == EV_SHORT || m_tdata[2:1] == EV_LONG ||
                  m_tdata[2:1] == EV_DOUBLE))
    else $error("illegal event code");

  // a newly raised event valid follows a valid scan in the scan register on the cycle before
  a_event_has_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(scan_valid))
    else $error("event without a scan");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("event register not cleared by reset");

endmodule
`default_nettype wire
